@@ sv/uht_pkg.sv @@
// ============================================================================
// uht_pkg
// shared types and constants of the identifier handle table
// ============================================================================
`default_nettype none
package uht_pkg;
   localparam int UID_DEPTH_DEFAULT  = 64;
   localparam int RESV_DEPTH_DEFAULT = 64;
   localparam int UID_W    = 48;
   localparam int HANDLE_W = 16;
   localparam int OWNER_W  = 128;
   localparam logic [31:0] FIRST_ID_RESET = 32'd1;

   typedef enum logic [1:0] {
      CMD_ADD_STATIC  = 2'd0,
      CMD_ADD_DYNAMIC = 2'd1,
      CMD_LOOKUP      = 2'd2,
      CMD_UNUSED      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_PRESENT = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;
endpackage
`default_nettype wire

@@ sv/uht_ram.sv @@
// ============================================================================
// uht_ram
// generic ram with one write port and one read port, registered read
// ============================================================================
`default_nettype none
module uht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ sv/uid_handle_table_with_dynamic_ids.sv @@
// ============================================================================
// uid_handle_table_with_dynamic_ids
// identifier to handle table with dynamic id assignment by owner
// ============================================================================
// steps: lookup scans the identifier memory, static add scans it and then writes, dynamic
// add scans the reservation memory, then the identifier memory once per id that it tries
// throughput: one request at a time, the next is taken once the response is loaded;
// a dynamic add to a full identifier table or an unknown command skips the scans
// the scans are set by the one read port of each memory
// synchronous reset clears valid bits and loads the counter with 1
`default_nettype none
module uid_handle_table_with_dynamic_ids #(
   parameter int UID_TABLE_DEPTH  = uht_pkg::UID_DEPTH_DEFAULT,
   parameter int RESV_TABLE_DEPTH = uht_pkg::RESV_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_uid_manufacturer,
   input  wire logic [31:0] req_uid_device,
   input  wire logic [15:0] req_conn_handle,
   input  wire logic [63:0] req_owner_id_high,
   input  wire logic [63:0] req_owner_id_low,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_out_manufacturer,
   output logic [31:0]      rsp_out_device_id,
   output logic [15:0]      rsp_out_handle,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_first_device_id
);
   localparam int UA = $clog2(UID_TABLE_DEPTH);
   localparam int RA = $clog2(RESV_TABLE_DEPTH);
   localparam int UC = UA + 1;
   localparam int RC = RA + 1;
   localparam int EW = uht_pkg::UID_W + uht_pkg::HANDLE_W;
   localparam int VW = uht_pkg::OWNER_W + uht_pkg::UID_W;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_USCAN = 9'b000000010,
      S_UEND  = 9'b000000100,
      S_RSCAN = 9'b000001000,
      S_REND  = 9'b000010000,
      S_PSCAN = 9'b000100000,
      S_PEND  = 9'b001000000,
      S_WRITE = 9'b010000000,
      S_RESP  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [UID_TABLE_DEPTH-1:0]  uvalid_ff, uvalid_in;
   logic [RESV_TABLE_DEPTH-1:0] rvalid_ff, rvalid_in;
   logic [31:0] next_id_ff, next_id_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [15:0] manu_ff, manu_in, handle_ff, handle_in;
   logic [127:0] owner_ff, owner_in;
   logic [UC-1:0] ucnt_ff, ucnt_in;
   logic [RC-1:0] rcnt_ff, rcnt_in;
   logic        hit_ff, hit_in;
   logic [15:0] hit_handle_ff, hit_handle_in;
   logic        rhit_ff, rhit_in;
   logic [47:0] target_ff, target_in;
   logic        wr_resv_ff, wr_resv_in, wr_uid_ff, wr_uid_in;
   logic [1:0]  st_ff, st_in;
   logic [15:0] o_manu_ff, o_manu_in, o_handle_ff, o_handle_in;
   logic [31:0] o_dev_ff, o_dev_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic          ufree, rfree;
   logic [UA-1:0] ufree_idx;
   logic [RA-1:0] rfree_idx;
   logic [UA-1:0] u_rd_addr;
   logic [RA-1:0] r_rd_addr;
   logic [EW-1:0] u_rd_data, u_wr_data;
   logic [VW-1:0] r_rd_data, r_wr_data;
   logic          u_wr_en, r_wr_en;
   logic          uprev_valid, rprev_valid;
   logic          uread_hit, rread_hit;

   uht_ram #(.WIDTH(EW), .DEPTH(UID_TABLE_DEPTH)) u_uid_ram (
      .clock(clock), .wr_en(u_wr_en), .wr_addr(ufree_idx), .wr_data(u_wr_data),
      .rd_addr(u_rd_addr), .rd_data(u_rd_data));
   uht_ram #(.WIDTH(VW), .DEPTH(RESV_TABLE_DEPTH)) u_resv_ram (
      .clock(clock), .wr_en(r_wr_en), .wr_addr(rfree_idx), .wr_data(r_wr_data),
      .rd_addr(r_rd_addr), .rd_data(r_rd_data));

   // lowest free slots
   always_comb begin
      ufree = 1'b0;
      ufree_idx = '0;
      for (int i = UID_TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!uvalid_ff[i]) begin
            ufree = 1'b1;
            ufree_idx = UA'(i);
         end
      end
      rfree = 1'b0;
      rfree_idx = '0;
      for (int i = RESV_TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!rvalid_ff[i]) begin
            rfree = 1'b1;
            rfree_idx = RA'(i);
         end
      end
   end

   assign u_rd_addr = ucnt_ff[UA-1:0];
   assign r_rd_addr = rcnt_ff[RA-1:0];
   assign uprev_valid = (ucnt_ff != '0) && uvalid_ff[UA'(ucnt_ff - UC'(1))];
   assign rprev_valid = (rcnt_ff != '0) && rvalid_ff[RA'(rcnt_ff - RC'(1))];
   assign uread_hit = uprev_valid && (u_rd_data[EW-1 -: 48] == target_ff);
   assign rread_hit = rprev_valid && (r_rd_data[VW-1 -: 128] == owner_ff);
   assign u_wr_en = (state_ff == S_WRITE) && wr_uid_ff;
   assign r_wr_en = (state_ff == S_WRITE) && wr_resv_ff;
   assign u_wr_data = {target_ff, handle_ff};
   assign r_wr_data = {owner_ff, target_ff};

   always_comb begin
      state_in = state_ff;
      uvalid_in = uvalid_ff;
      rvalid_in = rvalid_ff;
      next_id_in = next_id_ff;
      cmd_in = cmd_ff;
      manu_in = manu_ff;
      handle_in = handle_ff;
      owner_in = owner_ff;
      ucnt_in = ucnt_ff;
      rcnt_in = rcnt_ff;
      hit_in = hit_ff;
      hit_handle_in = hit_handle_ff;
      rhit_in = rhit_ff;
      target_in = target_ff;
      wr_resv_in = wr_resv_ff;
      wr_uid_in = wr_uid_ff;
      st_in = st_ff;
      o_manu_in = o_manu_ff;
      o_dev_in = o_dev_ff;
      o_handle_in = o_handle_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid && state_ff == S_IDLE) begin
         next_id_in = csr_first_device_id;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_command;
               manu_in = req_uid_manufacturer;
               handle_in = req_conn_handle;
               owner_in = {req_owner_id_high, req_owner_id_low};
               target_in = {req_uid_manufacturer, req_uid_device};
               ucnt_in = '0;
               rcnt_in = '0;
               hit_in = 1'b0;
               rhit_in = 1'b0;
               hit_handle_in = '0;
               wr_resv_in = 1'b0;
               wr_uid_in = 1'b0;
               st_in = uht_pkg::ST_MISSING;
               o_manu_in = '0;
               o_dev_in = '0;
               o_handle_in = '0;
               unique case (uht_pkg::cmd_type'(req_command))
                  uht_pkg::CMD_ADD_STATIC, uht_pkg::CMD_LOOKUP: state_in = S_USCAN;
                  uht_pkg::CMD_ADD_DYNAMIC: begin
                     if (!ufree) begin
                        st_in = uht_pkg::ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_RSCAN;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_USCAN, S_PSCAN: begin
            if (uread_hit && !hit_in) begin
               hit_in = 1'b1;
               hit_handle_in = u_rd_data[15:0];
            end
            ucnt_in = ucnt_ff + UC'(1);
            if (ucnt_ff == UC'(UID_TABLE_DEPTH - 1)) begin
               state_in = (state_ff == S_USCAN) ? S_UEND : S_PEND;
            end
         end
         S_UEND, S_PEND: begin
            logic h;
            h = hit_ff || uread_hit;
            if (uread_hit && !hit_ff) begin
               hit_handle_in = u_rd_data[15:0];
            end
            ucnt_in = '0;
            hit_in = 1'b0;
            if (state_ff == S_PEND) begin
               if (rhit_ff) begin
                  wr_uid_in = !h;
                  state_in = S_WRITE;
               end else if (h) begin
                  target_in = {manu_ff, next_id_ff};
                  next_id_in = next_id_ff + 32'd1;
                  state_in = S_PSCAN;
               end else begin
                  wr_uid_in = 1'b1;
                  wr_resv_in = 1'b1;
                  state_in = S_WRITE;
               end
            end else if (cmd_ff == uht_pkg::CMD_LOOKUP) begin
               if (h) begin
                  st_in = uht_pkg::ST_OK;
                  o_handle_in = (uread_hit && !hit_ff) ? u_rd_data[15:0] : hit_handle_ff;
               end
               state_in = S_RESP;
            end else if (h) begin
               st_in = uht_pkg::ST_PRESENT;
               state_in = S_RESP;
            end else if (!ufree) begin
               st_in = uht_pkg::ST_FULL;
               state_in = S_RESP;
            end else begin
               wr_uid_in = 1'b1;
               state_in = S_WRITE;
            end
         end
         S_RSCAN: begin
            if (rread_hit && !rhit_ff) begin
               rhit_in = 1'b1;
               target_in = r_rd_data[47:0];
            end
            rcnt_in = rcnt_ff + RC'(1);
            if (rcnt_ff == RC'(RESV_TABLE_DEPTH - 1)) begin
               state_in = S_REND;
            end
         end
         S_REND: begin
            logic rh;
            rh = rhit_ff || rread_hit;
            if (rread_hit && !rhit_ff) begin
               target_in = r_rd_data[47:0];
            end
            rhit_in = rh;
            if (rh) begin
               state_in = S_PSCAN;
            end else if (!rfree) begin
               st_in = uht_pkg::ST_FULL;
               state_in = S_RESP;
            end else begin
               target_in = {manu_ff, next_id_ff};
               next_id_in = next_id_ff + 32'd1;
               state_in = S_PSCAN;
            end
            ucnt_in = '0;
            hit_in = 1'b0;
         end
         S_WRITE: begin
            if (wr_uid_ff) begin
               uvalid_in[ufree_idx] = 1'b1;
            end
            if (wr_resv_ff) begin
               rvalid_in[rfree_idx] = 1'b1;
            end
            st_in = uht_pkg::ST_OK;
            if (cmd_ff == uht_pkg::CMD_ADD_DYNAMIC) begin
               o_manu_in = target_ff[47:32];
               o_dev_in = target_ff[31:0];
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         uvalid_ff <= '0;
         rvalid_ff <= '0;
         next_id_ff <= uht_pkg::FIRST_ID_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         uvalid_ff <= uvalid_in;
         rvalid_ff <= rvalid_in;
         next_id_ff <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      manu_ff <= manu_in;
      handle_ff <= handle_in;
      owner_ff <= owner_in;
      ucnt_ff <= ucnt_in;
      rcnt_ff <= rcnt_in;
      hit_ff <= hit_in;
      hit_handle_ff <= hit_handle_in;
      rhit_ff <= rhit_in;
      target_ff <= target_in;
      wr_resv_ff <= wr_resv_in;
      wr_uid_ff <= wr_uid_in;
      st_ff <= st_in;
      o_manu_ff <= o_manu_in;
      o_dev_ff <= o_dev_in;
      o_handle_ff <= o_handle_in;
   end

   logic [1:0]  rsp_status_ff;
   logic [15:0] rsp_manu_ff, rsp_handle_ff;
   logic [31:0] rsp_dev_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_RESP && !rsp_valid_ff) begin
         rsp_status_ff <= st_ff;
         rsp_manu_ff <= o_manu_ff;
         rsp_dev_ff <= o_dev_ff;
         rsp_handle_ff <= o_handle_ff;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_out_manufacturer = rsp_manu_ff;
   assign rsp_out_device_id = rsp_dev_ff;
   assign rsp_out_handle = rsp_handle_ff;
endmodule
`default_nettype wire

@@ sv/uht_checker.sv @@
// ============================================================================
// uht_checker
// port level checks of the identifier handle table
// ============================================================================
`default_nettype none
module uht_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [15:0] rsp_out_manufacturer,
   input wire logic [31:0] rsp_out_device_id,
   input wire logic [15:0] rsp_out_handle
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken too early");
   a_handle_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != uht_pkg::ST_OK |-> rsp_out_handle == 16'd0)
      else $error("handle on failed request");
   a_id_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != uht_pkg::ST_OK |-> rsp_out_device_id == 32'd0
         && rsp_out_manufacturer == 16'd0)
      else $error("id on failed request");
endmodule

bind uid_handle_table_with_dynamic_ids uht_checker u_uht_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
   .rsp_out_manufacturer(rsp_out_manufacturer),
   .rsp_out_device_id(rsp_out_device_id), .rsp_out_handle(rsp_out_handle));
`default_nettype wire
